### sv/swme_pkg.sv
// Package: sizes, types and constants of the sliding-window envelope block.
`timescale 1ns / 1ps
`default_nettype none
package swme_pkg;
	localparam int MAX_RADIUS  = 31;
	localparam int SAMPLE_BITS = 16;
	localparam int RADIUS_BITS = 5;
	localparam int WIN_DEPTH   = 2 * MAX_RADIUS + 1;
	localparam int CNT_BITS    = $clog2(WIN_DEPTH + 1);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [RADIUS_BITS-1:0]        radius_t;
	typedef logic [CNT_BITS-1:0]           cnt_t;

	localparam sample_t SAMPLE_MIN = sample_t'({1'b1, {(SAMPLE_BITS-1){1'b0}}});
	localparam sample_t SAMPLE_MAX = sample_t'({1'b0, {(SAMPLE_BITS-1){1'b1}}});

	// running max/min travelling down the cell row
	typedef struct packed {
		logic    valid;
		cnt_t    left;
		sample_t hi;
		sample_t lo;
	} tok_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HOLD
	} state_t;
endpackage
`default_nettype wire

### sv/swme_ifs.sv
// Channel interfaces: sample in, envelope out, radius write.
`timescale 1ns / 1ps
`default_nettype none
interface swme_in_if;
	import swme_pkg::*;
	logic    valid;
	logic    ready;
	sample_t sample;
	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface swme_out_if;
	import swme_pkg::*;
	logic    valid;
	logic    ready;
	sample_t upper;
	sample_t lower;
	modport source (output valid, output upper, output lower, input ready);
	modport sink (input valid, input upper, input lower, output ready);
endinterface

interface swme_cfg_if;
	import swme_pkg::*;
	logic    valid;
	logic    ready;
	radius_t radius;
	modport source (output valid, output radius, input ready);
	modport sink (input valid, input radius, output ready);
endinterface
`default_nettype wire

### sv/swme_cell.sv
// Window cell: holds one sample, merges it into the passing max/min request.
`timescale 1ns / 1ps
`default_nettype none
module swme_cell
	import swme_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    shift_en,
	input  wire sample_t samp_in,
	input  wire tok_t    tok_in,
	output sample_t      samp_q,
	output tok_t         tok_q
);
	logic    live;
	logic    valid_q;
	cnt_t    left_q;
	sample_t hi_q;
	sample_t lo_q;

	assign live = tok_in.valid && (tok_in.left != '0);

	always_ff @(posedge clk) begin
		if (shift_en) begin
			samp_q <= samp_in;
		end
		left_q <= tok_in.left - cnt_t'(1);
		hi_q   <= (samp_q > tok_in.hi) ? samp_q : tok_in.hi;
		lo_q   <= (samp_q < tok_in.lo) ? samp_q : tok_in.lo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= live;
		end
	end

	assign tok_q = {valid_q, left_q, hi_q, lo_q};
endmodule
`default_nettype wire

### sv/swme_ctrl.sv
// Controller: sample count, radius, request launch, result collection, output register.
`timescale 1ns / 1ps
`default_nettype none
module swme_ctrl
	import swme_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	swme_in_if.sink         samples,
	swme_out_if.source      envelope,
	swme_cfg_if.sink        cfg,
	input  wire tok_t       tok [WIN_DEPTH],
	output logic            shift_en,
	output tok_t            inject
);
	state_t  st_q, st_nxt;
	radius_t radius_q;
	cnt_t    cnt_q, cnt_nxt, r_eff, span, len;
	logic    emit, done, out_free, load_out, load_pend, launch_q;
	cnt_t    len_q;
	sample_t done_hi, done_lo, pend_hi_q, pend_lo_q, upper_q, lower_q;
	logic    out_valid_q;

	assign cfg.ready = 1'b1;

	assign r_eff   = (int'(radius_q) > MAX_RADIUS) ? cnt_t'(MAX_RADIUS) : cnt_t'(radius_q);
	assign span    = (r_eff << 1) + cnt_t'(1);
	assign cnt_nxt = (int'(cnt_q) < WIN_DEPTH) ? cnt_q + cnt_t'(1) : cnt_q;
	assign emit    = cnt_nxt > r_eff;
	assign len     = (cnt_nxt < span) ? cnt_nxt : span;

	assign shift_en = samples.valid && samples.ready;
	assign out_free = !out_valid_q || envelope.ready;

	always_comb begin
		done    = 1'b0;
		done_hi = SAMPLE_MIN;
		done_lo = SAMPLE_MAX;
		for (int k = 0; k < WIN_DEPTH; k++) begin
			if (tok[k].valid && tok[k].left == '0) begin
				done    = 1'b1;
				done_hi = tok[k].hi;
				done_lo = tok[k].lo;
			end
		end
	end

	always_comb begin
		st_nxt = st_q;
		case (st_q)
			ST_IDLE: begin
				if (shift_en && emit) begin
					st_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (done) begin
					st_nxt = out_free ? ST_IDLE : ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					st_nxt = ST_IDLE;
				end
			end
			default: st_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		samples.ready = 1'b0;
		load_out      = 1'b0;
		load_pend     = 1'b0;
		case (st_q)
			ST_IDLE: samples.ready = 1'b1;
			ST_SCAN: begin
				load_out  = done && out_free;
				load_pend = done && !out_free;
			end
			ST_HOLD: load_out = out_free;
			default: ;
		endcase
	end

	assign inject.valid = launch_q;
	assign inject.left  = len_q;
	assign inject.hi    = SAMPLE_MIN;
	assign inject.lo    = SAMPLE_MAX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			radius_q    <= '0;
			cnt_q       <= '0;
			launch_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q     <= st_nxt;
			launch_q <= shift_en && emit;
			if (cfg.valid && cfg.ready) begin
				radius_q <= cfg.radius;
			end
			if (shift_en) begin
				cnt_q <= cnt_nxt;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (envelope.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			len_q <= len;
		end
		if (load_pend) begin
			pend_hi_q <= done_hi;
			pend_lo_q <= done_lo;
		end
		if (load_out) begin
			upper_q <= (st_q == ST_HOLD) ? pend_hi_q : done_hi;
			lower_q <= (st_q == ST_HOLD) ? pend_lo_q : done_lo;
		end
	end

	assign envelope.valid = out_valid_q;
	assign envelope.upper = upper_q;
	assign envelope.lower = lower_q;
endmodule
`default_nettype wire

### sv/sliding_window_min_max_envelope.sv
// Top level: sliding-window min/max envelope over a row of sample cells.
//
//  channel   | role  | payload
//  ----------+-------+----------------------------
//  samples   | sink  | sample (signed 16)
//  envelope  | src   | upper, lower (signed 16)
//  cfg       | sink  | radius (5), always ready
//
// A warm-up sample is taken without launching a request. Otherwise the max/min request walks the
// cell row one cell per cycle until len = min(count, 2r+1) cells are merged;
// next sample taken once the result sits in the output register.
// Reset clears count, radius and control; cell contents are not cleared.
// A stalled output holds the result; the block then stops taking samples.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_min_max_envelope
	import swme_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	swme_in_if.sink    samples,
	swme_out_if.source envelope,
	swme_cfg_if.sink   cfg
);
	sample_t samp [WIN_DEPTH+1];
	tok_t    tok  [WIN_DEPTH+1];
	tok_t    tok_out [WIN_DEPTH];
	logic    shift_en;

	assign samp[0] = samples.sample;

	swme_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples),
		.envelope (envelope),
		.cfg      (cfg),
		.tok      (tok_out),
		.shift_en (shift_en),
		.inject   (tok[0])
	);

	for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
		swme_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.samp_in  (samp[k]),
			.tok_in   (tok[k]),
			.samp_q   (samp[k+1]),
			.tok_q    (tok[k+1])
		);
		assign tok_out[k] = tok[k+1];
	end
endmodule
`default_nettype wire

### verif/tb_sliding_window_min_max_envelope.sv
// Testbench for the sliding-window min/max envelope: directed and random streams.
`timescale 1ns / 1ps
module tb_sliding_window_min_max_envelope;
	import swme_pkg::*;

	localparam int DRAIN_CYCLES = 80;
	localparam int STALL_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_ITEMS  = 100;
	localparam int PHASES       = 11;

	typedef struct packed {
		sample_t upper;
		sample_t lower;
	} env_point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	swme_in_if  in_ch ();
	swme_out_if env_ch ();
	swme_cfg_if cfg_ch ();

	sliding_window_min_max_envelope u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (in_ch),
		.envelope (env_ch),
		.cfg      (cfg_ch)
	);

	// predictor state
	sample_t    window_mem [WIN_DEPTH];
	int         win_ptr = 0;
	int         seen_cnt = 0;
	radius_t    cur_radius = '0;
	env_point_t env_expect_q [$];

	int        err_cnt = 0;
	int        samples_sent = 0;
	int        points_checked = 0;
	int        idle_cycles = 0;
	int        hold_req = 0;
	bit        quiet = 1'b0;
	bit [31:0] radius_used = 32'h1;
	sample_t   drift_base = '0;

	always #6 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		err_cnt++;
	endtask

	function automatic bit predict_envelope(input sample_t s, output env_point_t pt);
		int      r;
		int      span;
		int      len;
		sample_t v;
		sample_t hi;
		sample_t lo;
		r = (cur_radius > MAX_RADIUS) ? MAX_RADIUS : int'(cur_radius);
		window_mem[win_ptr] = s;
		win_ptr = (win_ptr + 1) % WIN_DEPTH;
		if (seen_cnt < WIN_DEPTH)
			seen_cnt++;
		pt = '0;
		if (seen_cnt <= r)
			return 1'b0;
		span = 2 * r + 1;
		len = (seen_cnt < span) ? seen_cnt : span;
		hi = window_mem[(win_ptr + WIN_DEPTH - 1) % WIN_DEPTH];
		lo = hi;
		for (int k = 1; k < len; k++) begin
			v = window_mem[(win_ptr + 2 * WIN_DEPTH - 1 - k) % WIN_DEPTH];
			if (v > hi)
				hi = v;
			if (v < lo)
				lo = v;
		end
		pt.upper = hi;
		pt.lower = lo;
		return 1'b1;
	endfunction

	function automatic sample_t random_sample();
		case ($urandom_range(9))
			0: return SAMPLE_MIN;
			1: return SAMPLE_MAX;
			2, 3: return sample_t'($urandom);
			default: begin
				drift_base = drift_base + sample_t'(int'($urandom_range(512)) - 256);
				return drift_base;
			end
		endcase
	endfunction

	task automatic send_sample(input sample_t s);
		int         gap;
		env_point_t pt;
		gap = quiet ? 0 : $urandom_range(7);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.sample <= s;
		do @(posedge clk); while (!in_ch.ready);
		samples_sent++;
		if (predict_envelope(s, pt))
			env_expect_q.push_back(pt);
	endtask

	// block idle: no request pending, every point delivered, scan finished
	task automatic drain_envelope();
		in_ch.valid <= 1'b0;
		while (env_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_radius(input radius_t r);
		cfg_ch.valid <= 1'b1;
		cfg_ch.radius <= r;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		cur_radius = r;
		radius_used[r] = 1'b1;
	endtask

	task automatic test_reset_radius();
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		drain_envelope();
	endtask

	// warm-up gap, then windows clipped at the series start
	task automatic test_warmup();
		sample_t vals [8] = '{SAMPLE_MAX, SAMPLE_MIN, sample_t'(16'h0000), sample_t'(16'hFFFF),
			sample_t'(16'h5555), sample_t'(16'hAAAA), sample_t'(16'h0001), sample_t'(16'h7FFE)};
		write_radius(radius_t'(4));
		foreach (vals[i])
			send_sample(vals[i]);
		drain_envelope();
	endtask

	task automatic test_full_radius();
		sample_t vals [8] = '{sample_t'(16'h8001), sample_t'(16'h1234), SAMPLE_MIN,
			sample_t'(16'hFFFE), SAMPLE_MAX, sample_t'(16'h0000), sample_t'(16'hC000),
			sample_t'(16'h4000)};
		write_radius(radius_t'(MAX_RADIUS));
		foreach (vals[i])
			send_sample(vals[i]);
		drain_envelope();
	endtask

	// shrink the radius mid-series: stored samples reused as is
	task automatic test_radius_change();
		sample_t vals [5] = '{sample_t'(16'h0010), sample_t'(16'hFFF0), sample_t'(16'h0020),
			sample_t'(16'h0005), sample_t'(16'h8000)};
		write_radius(radius_t'(1));
		foreach (vals[i])
			send_sample(vals[i]);
		drain_envelope();
	endtask

	task automatic test_backpressure();
		write_radius(radius_t'(2));
		quiet = 1'b1;
		hold_req = HOLD_CYCLES;
		repeat (60)
			send_sample(random_sample());
		quiet = 1'b0;
		drain_envelope();
	endtask

	task automatic test_random_stream();
		radius_t r;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: r = '0;
				1, 6: r = radius_t'(MAX_RADIUS);
				default: r = radius_t'($urandom_range(MAX_RADIUS));
			endcase
			write_radius(r);
			quiet = (phase % 4 == 3);
			repeat (PHASE_ITEMS)
				send_sample(random_sample());
			quiet = 1'b0;
			drain_envelope();
		end
	endtask

	initial begin : envelope_sink
		int stall;
		env_ch.ready = 1'b0;
		forever begin
			if (hold_req > 0) begin
				env_ch.ready <= 1'b0;
				repeat (hold_req) @(posedge clk);
				hold_req = 0;
			end
			stall = quiet ? 0 : $urandom_range(7);
			if (stall > 0) begin
				env_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			env_ch.ready <= 1'b1;
			do @(posedge clk); while (!env_ch.valid);
		end
	end

	always @(posedge clk) begin : check_envelope
		env_point_t want;
		if (arst_n && env_ch.valid && env_ch.ready) begin
			if (env_expect_q.size() == 0) begin
				report_mismatch($sformatf("unexpected point upper=%0d lower=%0d",
					env_ch.upper, env_ch.lower));
			end else begin
				want = env_expect_q.pop_front();
				points_checked++;
				if (env_ch.upper !== want.upper)
					report_mismatch($sformatf("upper got %0d want %0d",
						env_ch.upper, $signed(want.upper)));
				if (env_ch.lower !== want.lower)
					report_mismatch($sformatf("lower got %0d want %0d",
						env_ch.lower, $signed(want.lower)));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (env_ch.valid && env_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Timeout: no request moved for %0d cycles", STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.sample = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.radius = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_radius();
		test_warmup();
		test_full_radius();
		test_radius_change();
		test_backpressure();
		test_random_stream();
		drain_envelope();
		$display("Covered %0d samples and %0d envelope points, %0d radius settings from 0 to %0d",
			samples_sent, points_checked, $countones(radius_used), MAX_RADIUS);
		$display("Warm-up, clipped series start, count saturation and a long output stall included");
		if (err_cnt == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

### sliding_window_min_max_envelope.f
sv/swme_pkg.sv
sv/swme_ifs.sv
sv/swme_cell.sv
sv/swme_ctrl.sv
sv/sliding_window_min_max_envelope.sv
verif/tb_sliding_window_min_max_envelope.sv
